>>> rtl/aes_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aes_pkg
// shared types, register indexes, s-box tables and field arithmetic
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int MAX_ROUNDS_DEF = 14;
  localparam int CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_0 = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_1 = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_2 = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_3 = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_LENGTH = 3'd4;

  localparam logic [1:0] KEY_LEN_128 = 2'd0;
  localparam logic [1:0] KEY_LEN_192 = 2'd1;
  localparam logic [1:0] KEY_LEN_256 = 2'd2;

  typedef struct packed {
    logic        mode;
    logic [63:0] block_high;
    logic [63:0] block_low;
  } aes_in_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } aes_out_t;

  // command from the sequencer to the key expansion
  typedef struct packed {
    logic       start;
    logic [1:0] len;
  } kexp_cmd_t;

  localparam logic [7:0] FWD_SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
    8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
    8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
    8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
    8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
    8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
    8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
    8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
    8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
    8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
    8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
    8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
    8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
    8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
    8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
    8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
    8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
    8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
    8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
    8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
    8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
    8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
    8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
    8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
    8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
    8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
    8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
    8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
    8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
    8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
    8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
    8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // multiply by a 4-bit constant in gf(2^8)
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [3:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int k = 0; k < 4; k++) begin
      if (b[k]) p = p ^ x;
      x = xtime(x);
    end
    return p;
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {FWD_SBOX[w[31:24]], FWD_SBOX[w[23:16]], FWD_SBOX[w[15:8]], FWD_SBOX[w[7:0]]};
  endfunction

endpackage
`default_nettype wire

>>> rtl/aes_round.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aes_round
// one full cipher round, forward or inverse, shared by all rounds
// ----------------------------------------------------------------------------
module aes_round (
  input  logic [127:0] st,
  input  logic [127:0] rk,
  input  logic         inverse,
  input  logic         last,
  output logic [127:0] nxt
);

  logic [7:0] b   [16];
  logic [7:0] k   [16];
  logic [7:0] sbf [16];
  logic [7:0] sbi [16];
  logic [7:0] t   [16];
  logic [7:0] m   [16];
  logic [7:0] o   [16];

  always_comb begin
    logic [3:0] m0, m1, m2, m3;
    int src;
    int dst;
    m0 = inverse ? 4'd14 : 4'd2;
    m1 = inverse ? 4'd11 : 4'd3;
    m2 = inverse ? 4'd13 : 4'd1;
    m3 = inverse ? 4'd9  : 4'd1;
    for (int i = 0; i < 16; i++) begin
      b[i] = st[127 - 8*i -: 8];
      k[i] = rk[127 - 8*i -: 8];
    end
    // shift rows folded into the s-box lookups
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        src = r + 4 * ((c + r) % 4);
        dst = r + 4 * c;
        sbf[dst] = aes_pkg::FWD_SBOX[b[src]];
        sbi[src] = aes_pkg::INV_SBOX[b[dst]];
      end
    end
    // inverse adds the key before mixing
    for (int i = 0; i < 16; i++) begin
      t[i] = inverse ? (sbi[i] ^ k[i]) : sbf[i];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        m[4*c + r] = aes_pkg::gf_mul(t[4*c + r], m0)
                   ^ aes_pkg::gf_mul(t[4*c + ((r + 1) % 4)], m1)
                   ^ aes_pkg::gf_mul(t[4*c + ((r + 2) % 4)], m2)
                   ^ aes_pkg::gf_mul(t[4*c + ((r + 3) % 4)], m3);
      end
    end
    for (int i = 0; i < 16; i++) begin
      if (inverse) o[i] = last ? t[i] : m[i];
      else         o[i] = (last ? t[i] : m[i]) ^ k[i];
      nxt[127 - 8*i -: 8] = o[i];
    end
  end

endmodule
`default_nettype wire

>>> rtl/aes_kexp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aes_kexp
// key expansion, one 32-bit word a cycle, into the round key memory
// ----------------------------------------------------------------------------
module aes_kexp #(
  parameter int MAX_ROUNDS = aes_pkg::MAX_ROUNDS_DEF,
  localparam int RW = $clog2(MAX_ROUNDS + 1),
  localparam int AW = RW + 1
) (
  input  logic                clk,
  input  logic                rst,
  input  aes_pkg::kexp_cmd_t  cmd,
  input  logic [255:0]        key,
  input  logic [AW-1:0]       rd_addr_a,
  input  logic [AW-1:0]       rd_addr_b,
  output logic [63:0]         rd_data_a,
  output logic [63:0]         rd_data_b,
  output logic [RW-1:0]       nr,
  output logic                busy
);

  localparam int DEPTH = 2 * (MAX_ROUNDS + 1);
  localparam logic [4:0] MAX_R5 = 5'(MAX_ROUNDS);

  logic [63:0]   store [DEPTH];
  logic          running;
  logic [RW+1:0] widx;
  logic [2:0]    phase;
  logic [7:0]    rc;
  logic [31:0]   win [8];

  logic [31:0] kwords [8];
  logic [31:0] word;
  logic [31:0] back;
  logic [31:0] tmp;
  logic [3:0]  nk;
  logic [2:0]  phase_last;
  logic [4:0]  nr_base;
  logic        in_key;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      kwords[i] = key[255 - 32*i -: 32];
    end
    nk      = 4'd4 + {1'b0, cmd.len, 1'b0};
    nr_base = 5'd10 + {2'b00, cmd.len, 1'b0};
    nr      = (nr_base > MAX_R5) ? RW'(MAX_ROUNDS) : RW'(nr_base);
    phase_last = 3'(nk - 4'd1);
    in_key  = widx < (RW+2)'(nk);
    case (cmd.len)
      aes_pkg::KEY_LEN_128: back = win[3];
      aes_pkg::KEY_LEN_192: back = win[5];
      default:              back = win[7];
    endcase
    tmp = win[0];
    if (phase == 3'd0) begin
      tmp = aes_pkg::sub_word({win[0][23:0], win[0][31:24]}) ^ {rc, 24'h000000};
    end else if (cmd.len == aes_pkg::KEY_LEN_256 && phase == 3'd4) begin
      tmp = aes_pkg::sub_word(win[0]);
    end
    word = in_key ? kwords[widx[2:0]] : (back ^ tmp);
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.start) begin
      running <= 1'b1;
      widx    <= '0;
      phase   <= '0;
      rc      <= 8'h01;
    end else if (running) begin
      widx  <= widx + 1'b1;
      phase <= (phase == phase_last) ? 3'd0 : phase + 3'd1;
      if (!in_key && phase == 3'd0) rc <= aes_pkg::xtime(rc);
      if (widx == {nr, 2'b11}) running <= 1'b0;
    end
  end

  // window of the last eight words, newest first
  always_ff @(posedge clk) begin
    if (running) begin
      win[0] <= word;
      for (int i = 1; i < 8; i++) win[i] <= win[i-1];
      if (widx[0]) store[widx[RW+1:1]] <= {win[0], word};
    end
  end

  always_ff @(posedge clk) begin
    rd_data_a <= store[rd_addr_a];
    rd_data_b <= store[rd_addr_b];
  end

  assign busy = running;

endmodule
`default_nettype wire

>>> rtl/aes_block_cipher_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aes_block_cipher_unit
// round-iterative aes-128/192/256 ecb encrypt and decrypt
//
//   channel  direction  handshake             payload
//   in       sink       in_valid / in_ready   aes_in_t  (mode, block)
//   out      source     out_valid / out_ready aes_out_t (result block)
//   cfg      sink       cfg_write             cfg_index, cfg_data
//
// an item passes from transfer through the initial key add (ADD0), nr rounds
// through the shared round unit (ROUND, nr = 10, 12 or 14) and the output
// load (DONE) into the output register.
// reset and every key register write run the key expansion: 4 * (nr + 1)
// words, one per cycle, during which in_ready is low.
// a result waiting on out_ready holds the core in its final state.
// ----------------------------------------------------------------------------
module aes_block_cipher_unit #(
  parameter int MAX_ROUNDS = aes_pkg::MAX_ROUNDS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  aes_pkg::aes_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output aes_pkg::aes_out_t               out_data,
  input  logic                            cfg_write,
  input  logic [aes_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [63:0]                     cfg_data
);

  localparam int RW = $clog2(MAX_ROUNDS + 1);

  typedef enum logic [1:0] {IDLE, ADD0, ROUND, DONE} state_t;

  state_t        state;
  logic [127:0]  st;
  logic          dec;
  logic [RW-1:0] kidx;
  logic          start_q;
  logic [63:0]   key_word_0, key_word_1, key_word_2, key_word_3;
  logic [1:0]    key_length;

  logic [RW-1:0]      kidx_next;
  logic [RW-1:0]      nr;
  logic               kbusy;
  logic [63:0]        rk_hi, rk_lo;
  logic [127:0]       round_out;
  logic               last;
  aes_pkg::kexp_cmd_t cmd;

  assign cmd.start = start_q;
  assign cmd.len   = (key_length == 2'd3) ? aes_pkg::KEY_LEN_256 : key_length;
  assign in_ready  = (state == IDLE) && !kbusy && !start_q && !cfg_write;
  assign last      = dec ? (kidx == '0) : (kidx == nr);

  always_comb begin
    kidx_next = kidx;
    unique case (state)
      IDLE:  kidx_next = in_data.mode ? nr : '0;
      ADD0:  kidx_next = dec ? kidx - 1'b1 : kidx + 1'b1;
      ROUND: if (!last) kidx_next = dec ? kidx - 1'b1 : kidx + 1'b1;
      DONE:  kidx_next = kidx;
    endcase
  end

  aes_kexp #(.MAX_ROUNDS(MAX_ROUNDS)) u_kexp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .key       ({key_word_0, key_word_1, key_word_2, key_word_3}),
    .rd_addr_a ({kidx_next, 1'b0}),
    .rd_addr_b ({kidx_next, 1'b1}),
    .rd_data_a (rk_hi),
    .rd_data_b (rk_lo),
    .nr        (nr),
    .busy      (kbusy)
  );

  aes_round u_round (
    .st      (st),
    .rk      ({rk_hi, rk_lo}),
    .inverse (dec),
    .last    (last),
    .nxt     (round_out)
  );

  always_ff @(posedge clk) begin
    kidx <= kidx_next;
    if (rst) begin
      state      <= IDLE;
      out_valid  <= 1'b0;
      start_q    <= 1'b0;
      key_word_0 <= '0;
      key_word_1 <= '0;
      key_word_2 <= '0;
      key_word_3 <= '0;
      key_length <= '0;
    end else begin
      // any write to a defined register restarts the key expansion
      start_q <= cfg_write && (cfg_index <= aes_pkg::REG_KEY_LENGTH);
      if (cfg_write) begin
        unique case (cfg_index)
          aes_pkg::REG_KEY_WORD_0: key_word_0 <= cfg_data;
          aes_pkg::REG_KEY_WORD_1: key_word_1 <= cfg_data;
          aes_pkg::REG_KEY_WORD_2: key_word_2 <= cfg_data;
          aes_pkg::REG_KEY_WORD_3: key_word_3 <= cfg_data;
          aes_pkg::REG_KEY_LENGTH: key_length <= cfg_data[1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready && state != DONE) out_valid <= 1'b0;
      unique case (state)
        IDLE: begin
          if (in_valid && in_ready) begin
            st    <= {in_data.block_high, in_data.block_low};
            dec   <= in_data.mode;
            state <= ADD0;
          end
        end
        ADD0: begin
          st    <= st ^ {rk_hi, rk_lo};
          state <= ROUND;
        end
        ROUND: begin
          st <= round_out;
          if (last) state <= DONE;
        end
        DONE: begin
          // wait for the output register to free up
          if (!out_valid || out_ready) begin
            out_data.result_high <= st[127:64];
            out_data.result_low  <= st[63:0];
            out_valid            <= 1'b1;
            state                <= IDLE;
          end
        end
      endcase
    end
  end

  a_reset_expands: assert property (@(posedge clk) rst |=> kbusy)
    else $error("key expansion not started by reset");

  a_accept_add: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state == ADD0)
    else $error("accepted item did not start the key add");

  a_round_index: assert property (@(posedge clk) disable iff (rst)
    (state == ROUND) |-> (kidx <= nr))
    else $error("round key index past the last round");

  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    (state == DONE && (!out_valid || out_ready)) |=> out_valid)
    else $error("finished block not loaded into output");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != IDLE || kbusy) |-> !in_ready)
    else $error("ready while core or key expansion busy");

endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// aes block cipher unit testbench
// drives blocks through the cipher under several keys and key lengths with
// random gaps and output stalls, and compares every result against an
// in-bench aes model built from the fips-197 round functions
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_DEPTH = 2 * (aes_pkg::MAX_ROUNDS_DEF + 1);
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 100;
  localparam int HOLD_CYCLES = 300;
  localparam logic [aes_pkg::CFG_INDEX_W-1:0] UNUSED_INDEX = 3'd7;

  // cipher model: key registers, expanded round keys, round functions
  class aes_model;
    logic [63:0] key_word[4];
    logic [1:0]  key_len;
    logic [63:0] round_keys[STORE_DEPTH];
    int          rounds;

    function void reset_state();
      for (int i = 0; i < 4; i++) key_word[i] = '0;
      key_len = aes_pkg::KEY_LEN_128;
      expand();
    endfunction

    function void write_reg(logic [aes_pkg::CFG_INDEX_W-1:0] idx, logic [63:0] data);
      case (idx)
        aes_pkg::REG_KEY_WORD_0: key_word[0] = data;
        aes_pkg::REG_KEY_WORD_1: key_word[1] = data;
        aes_pkg::REG_KEY_WORD_2: key_word[2] = data;
        aes_pkg::REG_KEY_WORD_3: key_word[3] = data;
        aes_pkg::REG_KEY_LENGTH: key_len = data[1:0];
        default: return;
      endcase
      expand();
    endfunction

    function void expand();
      logic [31:0] w[60];
      logic [31:0] t;
      logic [7:0]  rc;
      int len, nk, total;
      len = (key_len > 2) ? 2 : key_len;
      nk = 4 + 2 * len;
      rounds = nk + 6;
      if (rounds > aes_pkg::MAX_ROUNDS_DEF) rounds = aes_pkg::MAX_ROUNDS_DEF;
      total = 4 * (rounds + 1);
      for (int i = 0; i < 60; i++) w[i] = '0;
      for (int i = 0; i < nk; i++)
        w[i] = (i % 2 == 0) ? key_word[i / 2][63:32] : key_word[i / 2][31:0];
      rc = 8'h01;
      for (int i = nk; i < total && i < 60; i++) begin
        t = w[i - 1];
        if (i % nk == 0) begin
          t = aes_pkg::sub_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
          rc = aes_pkg::xtime(rc);
        end else if (nk > 6 && i % nk == 4) begin
          t = aes_pkg::sub_word(t);
        end
        w[i] = w[i - nk] ^ t;
      end
      for (int e = 0; e < STORE_DEPTH; e++)
        round_keys[e] = {(2 * e < total) ? w[2 * e] : 32'h0,
                         (2 * e + 1 < total) ? w[2 * e + 1] : 32'h0};
    endfunction

    function logic [7:0] mul(logic [7:0] a, logic [7:0] b);
      logic [7:0] p;
      p = 0;
      for (int k = 0; k < 8; k++) begin
        if (b[k]) p ^= a;
        a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
      end
      return p;
    endfunction

    function logic [127:0] add_key(logic [127:0] s, int r);
      return s ^ {round_keys[2 * r], round_keys[2 * r + 1]};
    endfunction

    // byte i of the state sits at bits 127-8i; column c holds bytes 4c..4c+3
    function logic [127:0] shift_sub(logic [127:0] s, bit inv);
      logic [127:0] t;
      int src, dst;
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++) begin
          src = r + 4 * ((c + r) % 4);
          dst = r + 4 * c;
          if (inv) t[127 - 8 * src -: 8] = aes_pkg::INV_SBOX[s[127 - 8 * dst -: 8]];
          else t[127 - 8 * dst -: 8] = aes_pkg::FWD_SBOX[s[127 - 8 * src -: 8]];
        end
      return t;
    endfunction

    function logic [127:0] mix(logic [127:0] s, bit inv);
      logic [7:0] a[4];
      logic [7:0] m[4];
      logic [127:0] t;
      if (inv) begin
        m[0] = 8'd14; m[1] = 8'd11; m[2] = 8'd13; m[3] = 8'd9;
      end else begin
        m[0] = 8'd2; m[1] = 8'd3; m[2] = 8'd1; m[3] = 8'd1;
      end
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 4; r++) a[r] = s[127 - 8 * (4 * c + r) -: 8];
        for (int r = 0; r < 4; r++)
          t[127 - 8 * (4 * c + r) -: 8] = mul(a[r], m[0]) ^ mul(a[(r + 1) % 4], m[1])
              ^ mul(a[(r + 2) % 4], m[2]) ^ mul(a[(r + 3) % 4], m[3]);
      end
      return t;
    endfunction

    function aes_pkg::aes_out_t cipher(aes_pkg::aes_in_t item);
      logic [127:0] s;
      s = {item.block_high, item.block_low};
      if (!item.mode) begin
        s = add_key(s, 0);
        for (int r = 1; r <= rounds; r++) begin
          s = shift_sub(s, 0);
          if (r != rounds) s = mix(s, 0);
          s = add_key(s, r);
        end
      end else begin
        s = add_key(s, rounds);
        for (int r = rounds - 1; r >= 0; r--) begin
          s = shift_sub(s, 1);
          s = add_key(s, r);
          if (r != 0) s = mix(s, 1);
        end
      end
      return '{result_high: s[127:64], result_low: s[63:0]};
    endfunction
  endclass

  class cipher_scoreboard;
    aes_model model;
    aes_pkg::aes_out_t pending_blocks[$];
    int mismatches;

    function new(aes_model m);
      model = m;
      mismatches = 0;
    endfunction

    function void note_block(aes_pkg::aes_in_t item);
      pending_blocks.insert(pending_blocks.size(), model.cipher(item));
    endfunction

    function void check_block(aes_pkg::aes_out_t got);
      aes_pkg::aes_out_t want;
      if (pending_blocks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending_blocks[0];
      pending_blocks.delete(0);
      if (got.result_high !== want.result_high || got.result_low !== want.result_low) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected %h_%h got %h_%h", want.result_high,
                   want.result_low, got.result_high, got.result_low);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  aes_pkg::aes_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  aes_pkg::aes_out_t out_data;
  logic cfg_write = 1'b0;
  logic [aes_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  aes_model key_model = new();
  cipher_scoreboard blocks_sb = new(key_model);
  int idle_cycles = 0;
  bit hold_request = 1'b0;
  bit sink_random = 1'b1;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  aes_block_cipher_unit i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // monitor: transfers at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) blocks_sb.note_block(in_data);
      if (out_valid && out_ready) blocks_sb.check_block(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: random wait before each transfer when sink_random is set, or one long hold-off when asked
  initial begin
    int stall;
    @(negedge clk);
    forever begin
      stall = sink_random ? $urandom_range(0, 13) : 0;
      if (hold_request) begin
        stall = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // leaves valid high after the transfer; the next call or drain() takes it
  task automatic send_block(bit mode, logic [63:0] hi, logic [63:0] lo, int max_gap);
    int gap;
    gap = (max_gap > 0) ? $urandom_range(0, max_gap) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{mode: mode, block_high: hi, block_low: lo};
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [aes_pkg::CFG_INDEX_W-1:0] idx, logic [63:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    key_model.write_reg(idx, data);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (blocks_sb.pending_blocks.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic load_key(logic [63:0] k0, k1, k2, k3, logic [1:0] len);
    drain();
    write_reg(aes_pkg::REG_KEY_WORD_0, k0);
    write_reg(aes_pkg::REG_KEY_WORD_1, k1);
    write_reg(aes_pkg::REG_KEY_WORD_2, k2);
    write_reg(aes_pkg::REG_KEY_WORD_3, k3);
    write_reg(aes_pkg::REG_KEY_LENGTH, len);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    key_model.reset_state();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // all-zero key after reset, then fips-197 example keys
    send_block(0, '0, '0, 0);
    send_block(1, '1, '1, 0);
    load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f, '0, '0, aes_pkg::KEY_LEN_128);
    send_block(0, 64'h0011223344556677, 64'h8899aabbccddeeff, 0);
    send_block(1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 0);
    load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h1011121314151617, '0,
             aes_pkg::KEY_LEN_192);
    send_block(0, 64'h0011223344556677, 64'h8899aabbccddeeff, 0);
    send_block(1, 64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191, 0);
    load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h1011121314151617,
             64'h18191a1b1c1d1e1f, aes_pkg::KEY_LEN_256);
    send_block(0, 64'h0011223344556677, 64'h8899aabbccddeeff, 0);
    send_block(1, 64'h8ea2b7ca516745bf, 64'heafc49904b496089, 0);
    send_block(0, '1, '0, 0);
    send_block(1, '0, '1, 0);
    // key length three acts as a 256-bit key; out of range index is ignored
    load_key('1, '1, '1, '1, 2'd3);
    write_reg(UNUSED_INDEX, 64'hdeadbeefdeadbeef);
    send_block(0, '1, '1, 0);
    send_block(1, '0, '0, 0);

    // back-to-back offers while the receiver holds off
    hold_request = 1'b1;
    for (int i = 0; i < 6; i++) send_block($urandom_range(0, 1), rand64(), rand64(), 0);

    for (int phase = 0; phase < 12; phase++) begin
      logic [1:0] len;
      len = (phase < 3) ? 2'(phase) : 2'($urandom_range(0, 3));
      if (phase == 3) load_key('0, '0, '0, '0, aes_pkg::KEY_LEN_256);
      else if (phase == 4) load_key('1, '1, '1, '1, aes_pkg::KEY_LEN_128);
      else load_key(rand64(), rand64(), rand64(), rand64(), len);
      sink_random = (phase % 4 != 1);
      for (int i = 0; i < 125; i++)
        send_block($urandom_range(0, 1), rand64(), rand64(), (phase % 4 == 1) ? 0 : 13);
    end

    drain();
    if (blocks_sb.mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
